// ----- src/pls_pkg.sv -----
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and constants of the positional list store: item payloads,
// operation and status codes, and the control word that drives the cell chain.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned STAT_W = 2;

  localparam logic [DATA_W-1:0] INIT_VALUE = DATA_W'(10);
  localparam logic [CNT_W-1:0]  INIT_FILL  = CNT_W'(1);
  localparam logic [CNT_W-1:0]  FULL_FILL  = CNT_W'(DEPTH);

  localparam logic [FUNC_W-1:0] FUNC_INS_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_INS_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_INS_AT    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DEL_FRONT = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DEL_BACK  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_DEL_AT    = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE    = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_TRAVERSE  = 3'd7;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic                     found;
    logic signed [DATA_W-1:0] element;
    logic                     last;
    logic [CNT_W-1:0]         length;
  } out_item_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [CNT_W-1:0]  idx;
    logic [CNT_W-1:0]  last_idx;
    logic [DATA_W-1:0] ins_value;
    logic [DATA_W-1:0] wrap_value;
  } cell_ctl_t;

endpackage

// ----- src/pls_cell.sv -----
// ----------------------------------------------------------------------------
// pls_cell
// One list slot. Holds, opens a gap, closes a gap or rotates toward the head,
// taking data from its left or right neighbor as the control word says.
// ----------------------------------------------------------------------------
module pls_cell
  import pls_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctl_t         ctl_i,
  input  logic [IDX_W-1:0]  index_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] data_q, data_d;
  logic [CNT_W-1:0]  pos;

  assign pos = CNT_W'(index_i);

  always_comb begin
    data_d = data_q;
    unique case (ctl_i.op)
      CELL_INS: begin
        if (pos == ctl_i.idx) begin
          data_d = ctl_i.ins_value;
        end else if (pos > ctl_i.idx) begin
          data_d = left_i;
        end
      end
      CELL_DEL: begin
        if (pos >= ctl_i.idx) begin
          data_d = right_i;
        end
      end
      CELL_ROT: begin
        if (pos == ctl_i.last_idx) begin
          data_d = ctl_i.wrap_value;
        end else if (pos < ctl_i.last_idx) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= INIT_VALUE;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

// ----- src/positional_list_store_core.sv -----
// ----------------------------------------------------------------------------
// positional_list_store_core
// Ordered list of up to DEPTH signed 32-bit values held in a chain of cells.
// ----------------------------------------------------------------------------
// On an insert or delete every cell shifts or holds at once, and
// the single result item is registered at the output. Update and traverse hold
// the input through the accepting cycle and then through one rotation step
// per element. Each step moves the list through cell 0, where one compare and
// add sees each element in order, and the last step leaves the list back in
// place. Traverse gives one item per element, update gives one item at the end.
// A new item is taken on the cycle after an insert or delete, and on the cycle
// after the last rotation step. A result item held at the output by a stall
// blocks both the input and the next rotation step until it is taken. After
// reset the list holds the single value 10.
// ----------------------------------------------------------------------------
module positional_list_store_core
  import pls_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_ROT  = 1'b1;

  logic              state_q, state_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  rot_cnt_q, rot_cnt_d;
  logic [CNT_W-1:0]  add_q, add_d;
  logic              found_q, found_d;
  logic              is_upd_q, is_upd_d;
  logic [DATA_W-1:0] match_q, match_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;

  logic [DATA_W-1:0] cell_data [DEPTH];
  cell_ctl_t         ctl;

  logic              slot_free;
  logic              in_fire;
  logic              step;
  logic              last_step;
  logic              head_match;
  logic              go_rot;
  logic [STAT_W-1:0] status;
  logic [CNT_W:0]    pos_ext;
  logic [CNT_W:0]    fill_ext;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !slot_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign step       = (state_q == ST_ROT) && slot_free;
  assign last_step  = (rot_cnt_q == fill_q - CNT_W'(1));
  assign head_match = is_upd_q && (cell_data[0] == match_q);
  assign pos_ext    = (CNT_W+1)'(in_item_i.position);
  assign fill_ext   = (CNT_W+1)'(fill_q);

  always_comb begin
    ctl            = '0;
    ctl.op         = CELL_HOLD;
    ctl.ins_value  = DATA_W'(in_item_i.value);
    ctl.last_idx   = fill_q - CNT_W'(1);
    ctl.wrap_value = head_match ? cell_data[0] + DATA_W'(add_q) : cell_data[0];
    status         = STAT_OK;
    go_rot         = 1'b0;
    fill_d         = fill_q;
    state_d        = state_q;
    rot_cnt_d      = rot_cnt_q;
    add_d          = add_q;
    found_d        = found_q;
    is_upd_d       = is_upd_q;
    match_d        = match_q;
    out_item_d     = out_item_q;
    out_valid_d    = out_valid_q && out_stall_i;

    if (in_fire) begin
      unique case (in_item_i.func)
        FUNC_INS_FRONT, FUNC_INS_BACK, FUNC_INS_AT: begin
          if (fill_q >= FULL_FILL) begin
            status = STAT_FULL;
          end else if (in_item_i.func == FUNC_INS_AT &&
                       (pos_ext == '0 || pos_ext > fill_ext + (CNT_W+1)'(1))) begin
            status = STAT_RANGE;
          end else begin
            ctl.op = CELL_INS;
            if (in_item_i.func == FUNC_INS_FRONT) begin
              ctl.idx = '0;
            end else if (in_item_i.func == FUNC_INS_BACK) begin
              ctl.idx = fill_q;
            end else begin
              ctl.idx = in_item_i.position - CNT_W'(1);
            end
            fill_d = fill_q + CNT_W'(1);
          end
        end
        FUNC_DEL_FRONT, FUNC_DEL_BACK: begin
          if (fill_q <= CNT_W'(1)) begin
            status = STAT_EMPTY;
          end else begin
            if (in_item_i.func == FUNC_DEL_FRONT) begin
              ctl.op  = CELL_DEL;
              ctl.idx = '0;
            end
            fill_d = fill_q - CNT_W'(1);
          end
        end
        FUNC_DEL_AT: begin
          if (pos_ext < (CNT_W+1)'(2) || pos_ext > fill_ext) begin
            status = STAT_RANGE;
          end else begin
            ctl.op  = CELL_DEL;
            ctl.idx = in_item_i.position - CNT_W'(1);
            fill_d  = fill_q - CNT_W'(1);
          end
        end
        default: begin
          go_rot    = 1'b1;
          state_d   = ST_ROT;
          rot_cnt_d = '0;
          add_d     = CNT_W'(1);
          found_d   = 1'b0;
          is_upd_d  = (in_item_i.func == FUNC_UPDATE);
          match_d   = DATA_W'(in_item_i.value);
        end
      endcase
      if (!go_rot) begin
        out_valid_d        = 1'b1;
        out_item_d.status  = status;
        out_item_d.found   = 1'b0;
        out_item_d.element = '0;
        out_item_d.last    = 1'b1;
        out_item_d.length  = fill_d;
      end
    end else if (step) begin
      ctl.op    = CELL_ROT;
      rot_cnt_d = rot_cnt_q + CNT_W'(1);
      if (head_match) begin
        add_d   = add_q + CNT_W'(1);
        found_d = 1'b1;
      end
      if (last_step) begin
        state_d = ST_IDLE;
      end
      if (!is_upd_q || last_step) begin
        out_valid_d        = 1'b1;
        out_item_d.status  = STAT_OK;
        out_item_d.found   = is_upd_q && (found_q || head_match);
        out_item_d.element = is_upd_q ? '0 : $signed(cell_data[0]);
        out_item_d.last    = last_step;
        out_item_d.length  = fill_q;
      end
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_W-1:0] left_data;
    logic [DATA_W-1:0] right_data;
    if (k == 0) begin : g_head
      assign left_data = '0;
    end else begin : g_left
      assign left_data = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_tail
      assign right_data = '0;
    end else begin : g_right
      assign right_data = cell_data[k+1];
    end
    pls_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .index_i (IDX_W'(k)),
      .left_i  (left_data),
      .right_i (right_data),
      .data_o  (cell_data[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= INIT_FILL;
      rot_cnt_q   <= '0;
      add_q       <= CNT_W'(1);
      found_q     <= 1'b0;
      is_upd_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rot_cnt_q   <= rot_cnt_d;
      add_q       <= add_d;
      found_q     <= found_d;
      is_upd_q    <= is_upd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_q    <= match_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q >= CNT_W'(1) && fill_q <= FULL_FILL)
    else $error("fill count out of range");

  a_rot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROT |-> rot_cnt_q < fill_q)
    else $error("rotation count passed the list length");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_item_i.func != FUNC_UPDATE && in_item_i.func != FUNC_TRAVERSE
    |=> out_valid_q && out_item_q.last && state_q == ST_IDLE)
    else $error("single-result operation did not post its item");

  a_rot_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_item_i.func == FUNC_UPDATE || in_item_i.func == FUNC_TRAVERSE)
    |=> state_q == ST_ROT && rot_cnt_q == '0 && $stable(fill_q))
    else $error("rotation did not start cleanly");

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for positional_list_store_core. A directed opening hits
// the single-element list, extreme values and the empty and range refusals.
// Random grow, shrink and mixed phases follow, driven in bursts against a
// receiver that stalls in changing patterns. Every result item is checked
// field by field against a list predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb;
  import pls_pkg::*;

  localparam int unsigned RAND_ITEMS   = 350;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned HOLD_AT_ITEM = 150;
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 8;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  in_item_t  pending_q[$];
  out_item_t expected_q[$];

  logic signed [DATA_W-1:0] list_cells [DEPTH];
  int unsigned list_len;
  int unsigned gen_len;

  int unsigned err_cnt   = 0;
  int unsigned sent_cnt  = 0;
  int unsigned cycle_cnt = 0;
  logic        took_item = 1'b0;

  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned rx_cycle   = 0;
  int unsigned hold_left  = 0;
  logic        hold_done  = 1'b0;

  positional_list_store_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    err_cnt++;
  endtask

  task automatic predict_list_op(input in_item_t it);
    logic [STAT_W-1:0] st;
    logic              hit;
    logic [DATA_W-1:0] step;
    out_item_t         res;
    int                idx;
    int                i;
    st   = STAT_OK;
    hit  = 1'b0;
    step = 1;
    idx  = -1;
    case (it.func)
      FUNC_INS_FRONT, FUNC_INS_BACK, FUNC_INS_AT: begin
        if (list_len >= DEPTH) begin
          st = STAT_FULL;
        end else if (it.func == FUNC_INS_FRONT) begin
          idx = 0;
        end else if (it.func == FUNC_INS_BACK) begin
          idx = list_len;
        end else if (it.position < 1 || it.position > list_len + 1) begin
          st = STAT_RANGE;
        end else begin
          idx = it.position - 1;
        end
        if (idx >= 0) begin
          for (i = list_len; i > idx; i--) list_cells[i] = list_cells[i-1];
          list_cells[idx] = it.value;
          list_len++;
        end
      end
      FUNC_DEL_FRONT, FUNC_DEL_BACK, FUNC_DEL_AT: begin
        if (it.func == FUNC_DEL_AT) begin
          if (it.position < 2 || it.position > list_len) st = STAT_RANGE;
          else idx = it.position - 1;
        end else if (list_len <= 1) begin
          st = STAT_EMPTY;
        end else begin
          idx = (it.func == FUNC_DEL_FRONT) ? 0 : list_len - 1;
        end
        if (idx >= 0) begin
          for (i = idx; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end
      end
      FUNC_UPDATE: begin
        for (i = 0; i < list_len; i++) begin
          if (list_cells[i] == it.value) begin
            list_cells[i] = list_cells[i] + step;
            step++;
            hit = 1'b1;
          end
        end
      end
      default: begin
        for (i = 0; i < list_len; i++) begin
          res.status  = STAT_OK;
          res.found   = 1'b0;
          res.element = list_cells[i];
          res.last    = (i + 1 == list_len);
          res.length  = CNT_W'(list_len);
          expected_q.push_back(res);
        end
        return;
      end
    endcase
    res.status  = st;
    res.found   = hit;
    res.element = '0;
    res.last    = 1'b1;
    res.length  = CNT_W'(list_len);
    expected_q.push_back(res);
  endtask

  // Track only the length so that random positions mostly land in range.
  task automatic push_list_op(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] v,
                              input int unsigned p);
    in_item_t it;
    it.func     = f;
    it.value    = v;
    it.position = CNT_W'(p);
    pending_q.push_back(it);
    case (f)
      FUNC_INS_FRONT, FUNC_INS_BACK:
        if (gen_len < DEPTH) gen_len++;
      FUNC_INS_AT:
        if (gen_len < DEPTH && p >= 1 && p <= gen_len + 1) gen_len++;
      FUNC_DEL_FRONT, FUNC_DEL_BACK:
        if (gen_len > 1) gen_len--;
      FUNC_DEL_AT:
        if (p >= 2 && p <= gen_len) gen_len--;
      default: ;
    endcase
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'd2;
      3:       return INIT_VALUE;
      4:       return 32'hFFFF_FFFF;
      5:       return 32'h7FFF_FFFF;
      6:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_position(input logic [FUNC_W-1:0] f);
    if ($urandom_range(0, 99) < 85) begin
      if (f == FUNC_INS_AT) return $urandom_range(1, gen_len + 1);
      if (f == FUNC_DEL_AT && gen_len >= 2) return $urandom_range(2, gen_len);
    end
    return $urandom_range(0, 31);
  endfunction

  task automatic build_directed();
    push_list_op(FUNC_TRAVERSE,  '0,           0);
    push_list_op(FUNC_UPDATE,    32'd5,        0);
    push_list_op(FUNC_UPDATE,    INIT_VALUE,   0);
    push_list_op(FUNC_DEL_FRONT, '0,           0);
    push_list_op(FUNC_DEL_BACK,  '0,           0);
    push_list_op(FUNC_DEL_AT,    '0,           1);
    push_list_op(FUNC_DEL_AT,    '0,           0);
    push_list_op(FUNC_INS_AT,    32'd3,        0);
    push_list_op(FUNC_INS_AT,    32'd3,        3);
    push_list_op(FUNC_INS_AT,    32'h7FFF_FFFF, 2);
    push_list_op(FUNC_INS_FRONT, 32'h8000_0000, 0);
    push_list_op(FUNC_INS_BACK,  32'h7FFF_FFFF, 31);
    push_list_op(FUNC_INS_AT,    32'hFFFF_FFFF, 5);
    push_list_op(FUNC_INS_AT,    32'd4,        31);
    push_list_op(FUNC_UPDATE,    32'h7FFF_FFFF, 0);
    push_list_op(FUNC_TRAVERSE,  '0,           0);
    push_list_op(FUNC_DEL_AT,    '0,           6);
    push_list_op(FUNC_DEL_AT,    '0,           5);
    push_list_op(FUNC_DEL_AT,    '0,           2);
    push_list_op(FUNC_DEL_FRONT, '0,           0);
    push_list_op(FUNC_DEL_BACK,  '0,           0);
    push_list_op(FUNC_INS_BACK,  32'd0,        31);
    push_list_op(FUNC_UPDATE,    32'd0,        0);
    push_list_op(FUNC_DEL_AT,    '0,           31);
    push_list_op(FUNC_TRAVERSE,  32'hFFFF_FFFF, 31);
  endtask

  // Grow until full, shrink down to one element, or mix freely.
  task automatic build_random();
    int unsigned made;
    int unsigned kind;
    int unsigned extra;
    int unsigned span;
    int unsigned r;
    logic [FUNC_W-1:0] f;
    made = 0;
    kind = 0;
    while (made < RAND_ITEMS) begin
      extra = $urandom_range(1, 4);
      span  = $urandom_range(10, 30);
      while (made < RAND_ITEMS && ((kind == 2) ? span > 0 : extra > 0)) begin
        r = $urandom_range(0, 99);
        case (kind)
          0: f = (r < 80) ? FUNC_W'($urandom_range(0, 2)) : FUNC_W'($urandom_range(3, 7));
          1: begin
            if (r < 80) begin
              f = FUNC_W'($urandom_range(3, 5));
            end else begin
              case ($urandom_range(0, 4))
                0:       f = FUNC_INS_FRONT;
                1:       f = FUNC_INS_BACK;
                2:       f = FUNC_INS_AT;
                3:       f = FUNC_UPDATE;
                default: f = FUNC_TRAVERSE;
              endcase
            end
          end
          default: f = FUNC_W'($urandom_range(0, 7));
        endcase
        push_list_op(f, pick_value(), pick_position(f));
        made++;
        if (span > 0) span--;
        if ((kind == 0 && gen_len == DEPTH) || (kind == 1 && gen_len == 1)) extra--;
      end
      kind = $urandom_range(0, 2);
    end
  endtask

  always @(posedge clk) begin
    took_item <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      predict_list_op(in_item);
      sent_cnt++;
    end
  end

  always @(negedge clk) begin : drive
    logic     nv;
    in_item_t ni;
    nv = in_valid;
    ni = in_item;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!in_valid || took_item) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() > 0) begin
        ni = pending_q.pop_front();
        nv = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else if ($urandom_range(0, 9) == 0) begin
          burst_left = 60;
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(0, 20);
          gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_valid <= nv;
    in_item  <= ni;
  end

  always @(negedge clk) begin : recv
    logic ns;
    rx_cycle++;
    if (!hold_done && sent_cnt >= HOLD_AT_ITEM) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      ns = 1'b1;
      hold_left--;
    end else begin
      case (rx_cycle[8:6])
        3'd0, 3'd1: ns = 1'b0;
        3'd2, 3'd3: ns = ($urandom_range(0, 99) < 30);
        3'd4:       ns = ($urandom_range(0, 99) < 75);
        3'd5:       ns = (rx_cycle % 3) != 0;
        default:    ns = rx_cycle[0];
      endcase
    end
    out_stall <= ns;
  end

  always @(posedge clk) begin : mon
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item element %0d", out_item.element));
      end else begin
        want = expected_q.pop_front();
        if (out_item.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", out_item.status, want.status));
        if (out_item.found !== want.found)
          report_mismatch($sformatf("found got %0b want %0b", out_item.found, want.found));
        if (out_item.element !== want.element)
          report_mismatch($sformatf("element got %0d want %0d", out_item.element,
                                    want.element));
        if (out_item.last !== want.last)
          report_mismatch($sformatf("last got %0b want %0b", out_item.last, want.last));
        if (out_item.length !== want.length)
          report_mismatch($sformatf("length got %0d want %0d", out_item.length,
                                    want.length));
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    foreach (list_cells[i]) list_cells[i] = '0;
    list_cells[0] = INIT_VALUE;
    list_len      = INIT_FILL;
    gen_len       = INIT_FILL;
    build_directed();
    build_random();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_q.size() != 0)
      report_mismatch($sformatf("%0d items never arrived", expected_q.size()));
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
